[rtl/core/positional_list_insert_delete_top_defines.svh]
// Assertion macros for the positional list block.
`ifndef POSITIONAL_LIST_INSERT_DELETE_TOP_DEFINES_SVH
`define POSITIONAL_LIST_INSERT_DELETE_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// Checks that the consequent holds in the same cycle as the antecedent.
`define PLID_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("positional list check failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define PLID_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("positional list check failed");

`else

`define PLID_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define PLID_ASSERT_NXT(lbl, clk, rstn, ante, cons)

`endif

`endif

[rtl/core/plid_pkg.sv]
`default_nettype none

package plid_pkg;

    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    localparam int OP_W     = 3;
    localparam int POS_W    = 6;
    localparam int VAL_W    = 32;
    localparam int STATUS_W = 2;
    localparam int EIDX_W   = 6;
    localparam int OCNT_W   = 7;

    // Wide enough for a position, a count and a count plus one.
    localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 48;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT_AT  = 3'd0,
        OP_DELETE_AT  = 3'd1,
        OP_PUSH_BACK  = 3'd2,
        OP_PUSH_FRONT = 3'd3,
        OP_POP_BACK   = 3'd4,
        OP_POP_FRONT  = 3'd5,
        OP_DUMP       = 3'd6,
        OP_NONE       = 3'd7
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2,
        ST_EMPTY = 2'd3
    } status_t;

    // Result layout from bit 0: status, entry_value, entry_index, count, zero pad.
    function automatic logic [M_TDATA_W-1:0] pack_result(
        input status_t            status,
        input logic [VAL_W-1:0]   entry_value,
        input logic [EIDX_W-1:0]  entry_index,
        input logic [OCNT_W-1:0]  count
    );
        logic [M_TDATA_W-1:0] word;
        word = '0;
        word[STATUS_W-1:0] = status;
        word[STATUS_W +: VAL_W] = entry_value;
        word[STATUS_W+VAL_W +: EIDX_W] = entry_index;
        word[STATUS_W+VAL_W+EIDX_W +: OCNT_W] = count;
        return word;
    endfunction

endpackage

`default_nettype wire

[rtl/core/plid_ram.sv]
`default_nettype none

module plid_ram #(
    parameter int DEPTH  = 16,
    parameter int WIDTH  = 32,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

[rtl/core/positional_list_insert_delete_top.sv]
// Positional list: an ordered list of up to DEPTH signed words.
// Commands arrive on the s_ stream, one command per transfer. Every command
// answers on the m_ stream; m_tlast marks the final transfer of a command.
// Edits (insert, delete, push, pop) give one transfer with a status and the
// new count; a dump gives one transfer per entry, or one with count zero
// when the list is empty. A refused edit leaves the list untouched.
// Entries live in a single-port-write, single-port-read RAM, and one shared
// index incrementer/decrementer walks it. Moving one entry is a read, then a
// write; an edit moves its entries one by one before its result is ready,
// and a refused edit goes straight to its result. A dump reads each entry,
// then sends it when the output register frees. s_tready is high only
// while the sequencer is idle; the next command can be taken while the last
// result still waits in the output register. A stalled m_tready holds the
// output register; the sequencer waits for it before loading the next result.
// aresetn (synchronous, active low) empties the list and drops m_tvalid;
// RAM contents are not cleared, and unused slots are never read.
`default_nettype none
`include "positional_list_insert_delete_top_defines.svh"

module positional_list_insert_delete_top import plid_pkg::*; (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,  // opcode[2:0], position[8:3], value[40:9]
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic      [M_TDATA_W-1:0] m_tdata,  // status[1:0], entry_value[33:2],
                                                // entry_index[39:34], count[46:40]
    output logic                      m_tlast
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_STEP,
        S_MOVE,
        S_DRD,
        S_DOUT,
        S_RES
    } state_t;

    state_t               state_reg;
    logic [CNT_W-1:0]     count_reg;
    logic [IDX_W-1:0]     idx_reg;
    logic [IDX_W-1:0]     end_reg;
    logic                 dir_up_reg;
    logic [DATA_WIDTH-1:0] value_reg;
    status_t              status_reg;
    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic                 m_tlast_reg;

    opcode_t              op;
    logic [POS_W-1:0]     pos;
    logic [VAL_W-1:0]     val;
    logic [CMP_W-1:0]     cnt_c;
    logic [CMP_W-1:0]     tgt_c;
    logic                 is_ins;
    logic                 is_del;
    logic                 is_full;
    logic                 is_empty;
    logic                 ins_in_range;
    logic                 del_in_range;
    logic [DATA_WIDTH+VAL_W-1:0] sv_wide;

    logic [IDX_W-1:0]     idx_nbr;
    logic                 at_end;
    logic                 out_free;
    logic                 out_load;
    logic                 dump_last;
    logic [IDX_W+6:0]     ei_wide;
    logic [DATA_WIDTH+VAL_W-1:0] ev_wide;

    logic                  ram_wr_en;
    logic [IDX_W-1:0]      ram_wr_addr;
    logic [DATA_WIDTH-1:0] ram_wr_data;
    logic                  ram_rd_en;
    logic [IDX_W-1:0]      ram_rd_addr;
    logic [DATA_WIDTH-1:0] ram_rd_data;

    // Command decode.
    always_comb begin
        op       = opcode_t'(s_tdata[OP_W-1:0]);
        pos      = s_tdata[OP_W +: POS_W];
        val      = s_tdata[OP_W+POS_W +: VAL_W];
        cnt_c    = CMP_W'(count_reg);
        is_full  = (count_reg == CNT_W'(DEPTH));
        is_empty = (count_reg == '0);
        is_ins   = 1'b0;
        is_del   = 1'b0;
        tgt_c    = CMP_W'(pos);
        case (op)
            OP_INSERT_AT: begin
                is_ins = 1'b1;
            end
            OP_PUSH_BACK: begin
                is_ins = 1'b1;
                tgt_c  = cnt_c + CMP_W'(1);
            end
            OP_PUSH_FRONT: begin
                is_ins = 1'b1;
                tgt_c  = CMP_W'(1);
            end
            OP_DELETE_AT: begin
                is_del = 1'b1;
            end
            OP_POP_BACK: begin
                is_del = 1'b1;
                tgt_c  = cnt_c;
            end
            OP_POP_FRONT: begin
                is_del = 1'b1;
                tgt_c  = CMP_W'(1);
            end
            default: begin
                is_ins = 1'b0;
            end
        endcase
        ins_in_range = (tgt_c != '0) && (tgt_c <= cnt_c + CMP_W'(1));
        del_in_range = (tgt_c != '0) && (tgt_c <= cnt_c);
        sv_wide      = {{DATA_WIDTH{val[VAL_W-1]}}, val};
    end

    // Shared index unit: one step toward the end of the move.
    assign idx_nbr   = dir_up_reg ? (idx_reg + IDX_W'(1)) : (idx_reg - IDX_W'(1));
    assign at_end    = (idx_reg == end_reg);
    assign out_free  = !m_tvalid_reg || m_tready;
    assign out_load  = ((state_reg == S_RES) || (state_reg == S_DOUT)) && out_free;
    assign dump_last = ((CNT_W'(idx_reg) + CNT_W'(1)) == count_reg);
    assign ei_wide   = (IDX_W+7)'(idx_reg) + (IDX_W+7)'(1);
    assign ev_wide   = {{VAL_W{1'b0}}, ram_rd_data};

    always_comb begin
        ram_rd_en   = ((state_reg == S_STEP) && !at_end) || (state_reg == S_DRD);
        ram_rd_addr = (state_reg == S_DRD) ? idx_reg : idx_nbr;
        ram_wr_en   = ((state_reg == S_STEP) && at_end && !dir_up_reg)
                      || (state_reg == S_MOVE);
        ram_wr_addr = idx_reg;
        ram_wr_data = (state_reg == S_MOVE) ? ram_rd_data : value_reg;
    end

    plid_ram #(
        .DEPTH (DEPTH),
        .WIDTH (DATA_WIDTH)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (m_tvalid_reg && m_tready && !out_load) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        value_reg  <= sv_wide[DATA_WIDTH-1:0];
                        status_reg <= ST_OK;
                        state_reg  <= S_RES;
                        if (is_ins) begin
                            if (is_full) begin
                                status_reg <= ST_FULL;
                            end else if (!ins_in_range) begin
                                status_reg <= ST_RANGE;
                            end else begin
                                idx_reg    <= IDX_W'(count_reg);
                                end_reg    <= IDX_W'(tgt_c - CMP_W'(1));
                                dir_up_reg <= 1'b0;
                                state_reg  <= S_STEP;
                            end
                        end else if (is_del) begin
                            if (is_empty) begin
                                status_reg <= ST_EMPTY;
                            end else if (!del_in_range) begin
                                status_reg <= ST_RANGE;
                            end else begin
                                idx_reg    <= IDX_W'(tgt_c - CMP_W'(1));
                                end_reg    <= IDX_W'(cnt_c - CMP_W'(1));
                                dir_up_reg <= 1'b1;
                                state_reg  <= S_STEP;
                            end
                        end else if ((op == OP_DUMP) && !is_empty) begin
                            idx_reg    <= '0;
                            dir_up_reg <= 1'b1;
                            state_reg  <= S_DRD;
                        end
                    end
                end
                S_STEP: begin
                    if (at_end) begin
                        // An insert writes its value into the opened slot here.
                        count_reg <= dir_up_reg ? (count_reg - CNT_W'(1))
                                                : (count_reg + CNT_W'(1));
                        state_reg <= S_RES;
                    end else begin
                        state_reg <= S_MOVE;
                    end
                end
                S_MOVE: begin
                    idx_reg   <= idx_nbr;
                    state_reg <= S_STEP;
                end
                S_DRD: begin
                    state_reg <= S_DOUT;
                end
                S_DOUT: begin
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        m_tlast_reg  <= dump_last;
                        m_tdata_reg  <= pack_result(ST_OK, ev_wide[VAL_W-1:0],
                                                    ei_wide[EIDX_W-1:0],
                                                    OCNT_W'(count_reg));
                        if (dump_last) begin
                            state_reg <= S_IDLE;
                        end else begin
                            idx_reg   <= idx_nbr;
                            state_reg <= S_DRD;
                        end
                    end
                end
                S_RES: begin
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        m_tlast_reg  <= 1'b1;
                        m_tdata_reg  <= pack_result(status_reg, '0, '0,
                                                    OCNT_W'(count_reg));
                        state_reg    <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    `PLID_ASSERT_IMP(a_count_bound, aclk, aresetn, 1'b1, count_reg <= CNT_W'(DEPTH))
    `PLID_ASSERT_NXT(a_count_step, aclk, aresetn, 1'b1, (count_reg == $past(count_reg)) || (count_reg == CNT_W'($past(count_reg) + CNT_W'(1))) || (count_reg == CNT_W'($past(count_reg) - CNT_W'(1))))
    `PLID_ASSERT_IMP(a_partial_dump, aclk, aresetn, m_tvalid && !m_tlast, (state_reg == S_DRD) || (state_reg == S_DOUT))

endmodule

`default_nettype wire
